/* src/scpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_pkg: shared constants for the sphere contact penalty force block
// Widths, register indexes, register reset values and the unit-vector one.
// ----------------------------------------------------------------------------
package scpf_pkg;

   localparam int Q_WIDTH       = 32;
   localparam int RADIUS_WIDTH  = 31;
   localparam int CSR_IDX_WIDTH = 3;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CURSOR_RADIUS     = 3'd0,
      CSR_NODE_RADIUS       = 3'd1,
      CSR_CONTACT_STIFFNESS = 3'd2,
      CSR_TABLE_HEIGHT      = 3'd3,
      CSR_TABLE_SPRING_GAIN = 3'd4
   } csr_index_type;

   localparam logic [RADIUS_WIDTH-1:0] CURSOR_RADIUS_RST     = 31'd6554;
   localparam logic [RADIUS_WIDTH-1:0] NODE_RADIUS_RST       = 31'd3277;
   localparam logic [RADIUS_WIDTH-1:0] CONTACT_STIFFNESS_RST = 31'd65536;
   localparam logic [Q_WIDTH-1:0]      TABLE_HEIGHT_RST      = 32'd0;
   localparam logic [RADIUS_WIDTH-1:0] TABLE_SPRING_GAIN_RST = 31'd65536;

   // One in Q1.30, the largest value a unit vector component can take.
   localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

endpackage
`default_nettype wire

/* src/scpf_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_req_if: request channel
// Cursor and node positions, signed Q16.16, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scpf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [scpf_pkg::Q_WIDTH-1:0] cursor_x;
   logic signed [scpf_pkg::Q_WIDTH-1:0] cursor_y;
   logic signed [scpf_pkg::Q_WIDTH-1:0] cursor_z;
   logic signed [scpf_pkg::Q_WIDTH-1:0] node_x;
   logic signed [scpf_pkg::Q_WIDTH-1:0] node_y;
   logic signed [scpf_pkg::Q_WIDTH-1:0] node_z;

   modport source (output valid, cursor_x, cursor_y, cursor_z, node_x, node_y, node_z,
                   input ready);
   modport sink (input valid, cursor_x, cursor_y, cursor_z, node_x, node_y, node_z,
                 output ready);
endinterface
`default_nettype wire

/* src/scpf_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_rsp_if: response channel
// Saturated node force, signed Q16.16, and the contact flag.
// ----------------------------------------------------------------------------
interface scpf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [scpf_pkg::Q_WIDTH-1:0] force_x;
   logic signed [scpf_pkg::Q_WIDTH-1:0] force_y;
   logic signed [scpf_pkg::Q_WIDTH-1:0] force_z;
   logic                                in_contact;

   modport source (output valid, force_x, force_y, force_z, in_contact, input ready);
   modport sink (input valid, force_x, force_y, force_z, in_contact, output ready);
endinterface
`default_nettype wire

/* src/sphere_contact_penalty_force.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_contact_penalty_force: penalty force between cursor and cloth node
// Fully pipelined contact force with table spring, one node per clock unless rsp_ch stalls.
// ----------------------------------------------------------------------------
// Usage. Each beat on req_ch carries the cursor center and one cloth node
// center. Each accepted beat yields exactly one beat on rsp_ch, in order,
// holding the saturated force on the node and the contact flag.
// Throughput is one beat per clock. The pipeline has 71 register stages: five
// for differences, squares and the contact test, 32 for the square root (one
// root bit per stage), 31 for the three unit-vector divisions (one quotient
// bit per stage), and three for the final multiply, sign and saturation.
// Each stage advances whenever the stage after it is empty or advancing, so
// bubbles close up and requests keep being accepted while a finished result
// waits on rsp_ch; a full pipeline with a stalled receiver holds every beat
// in place. The user must write the registers on csr_* only while no beat
// is in flight; the block itself does not enforce this. Reset empties the
// pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module sphere_contact_penalty_force (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   scpf_req_if.sink                                   req_ch,
   scpf_rsp_if.source                                 rsp_ch,
   input  wire logic                                  csr_we,
   input  wire logic [scpf_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [scpf_pkg::Q_WIDTH-1:0]          csr_wdata
);

   // Stage numbering.
   localparam int S_DIFF  = 1;
   localparam int S_MAG   = 2;
   localparam int S_SQ    = 3;
   localparam int S_SUM   = 4;
   localparam int S_CMP   = 5;
   localparam int S_SQRT0 = 6;
   localparam int NSQRT   = 32;
   localparam int S_DIV0  = S_SQRT0 + NSQRT;
   localparam int NDIV    = 31;
   localparam int S_PP    = S_DIV0 + NDIV;
   localparam int S_MQ    = S_PP + 1;
   localparam int S_OUT   = S_MQ + 1;
   localparam int NS      = S_OUT;

   // Per-item control carried down the front of the pipeline and the root.
   typedef struct packed {
      logic [2:0]       neg;
      logic             hit;
      logic [47:0]      tterm;
      logic [2:0][31:0] mag;
   } ctl_type;

   // Per-item state through the division stages.
   typedef struct packed {
      logic [2:0]       neg;
      logic             hit;
      logic [47:0]      tterm;
      logic [31:0]      len;
      logic [46:0]      kx;
      logic [2:0]       lsb;
      logic [2:0][31:0] rem;
      logic [2:0][30:0] q;
   } div_type;

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [30:0] cursor_radius_ff;
   logic [30:0] node_radius_ff;
   logic [30:0] contact_stiffness_ff;
   logic [31:0] table_height_ff;
   logic [30:0] table_spring_gain_ff;
   logic [31:0] r_ff;
   logic [63:0] rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_radius_ff     <= scpf_pkg::CURSOR_RADIUS_RST;
         node_radius_ff       <= scpf_pkg::NODE_RADIUS_RST;
         contact_stiffness_ff <= scpf_pkg::CONTACT_STIFFNESS_RST;
         table_height_ff      <= scpf_pkg::TABLE_HEIGHT_RST;
         table_spring_gain_ff <= scpf_pkg::TABLE_SPRING_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            scpf_pkg::CSR_CURSOR_RADIUS:     cursor_radius_ff     <= csr_wdata[30:0];
            scpf_pkg::CSR_NODE_RADIUS:       node_radius_ff       <= csr_wdata[30:0];
            scpf_pkg::CSR_CONTACT_STIFFNESS: contact_stiffness_ff <= csr_wdata[30:0];
            scpf_pkg::CSR_TABLE_HEIGHT:      table_height_ff      <= csr_wdata;
            scpf_pkg::CSR_TABLE_SPRING_GAIN: table_spring_gain_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // The summed radius is registered from the radius registers, and its square
   // is registered from the summed radius.
   always_ff @(posedge clock) begin
      r_ff  <= {1'b0, cursor_radius_ff} + {1'b0, node_radius_ff};
      rr_ff <= {32'b0, r_ff} * {32'b0, r_ff};
   end

   // ------------------------------------------------------------------------
   // Stage valids and the advance chain. A stage may load when it is empty
   // or when its content moves on in the same cycle.
   // ------------------------------------------------------------------------
   logic [NS:1]   vld_ff;
   logic [NS+1:1] en;

   always_comb begin
      en[NS+1] = rsp_ch.ready;
      for (int k = NS; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[S_DIFF]) begin
            vld_ff[S_DIFF] <= req_ch.valid;
         end
         for (int k = S_DIFF + 1; k <= NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ch.ready = en[S_DIFF];

   // ------------------------------------------------------------------------
   // Stage 1: difference vector node - cursor and the table depth.
   // ------------------------------------------------------------------------
   logic [32:0] v_ff [3];
   logic [33:0] depth_ff;

   always_ff @(posedge clock) begin
      if (en[S_DIFF]) begin
         v_ff[0]  <= {req_ch.node_x[31], req_ch.node_x} - {req_ch.cursor_x[31], req_ch.cursor_x};
         v_ff[1]  <= {req_ch.node_y[31], req_ch.node_y} - {req_ch.cursor_y[31], req_ch.cursor_y};
         v_ff[2]  <= {req_ch.node_z[31], req_ch.node_z} - {req_ch.cursor_z[31], req_ch.cursor_z};
         depth_ff <= {3'b000, node_radius_ff} + {{2{table_height_ff[31]}}, table_height_ff}
                     - {{2{req_ch.node_z[31]}}, req_ch.node_z};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: magnitudes, signs, the per-axis range test and the clamped table depth.
   // ------------------------------------------------------------------------
   logic [32:0] mag_abs [3];
   logic [2:0]  far_vec;
   logic [31:0] mag_ff [3];
   logic [2:0]  neg_ff;
   logic        far_ff;
   logic [32:0] tpos_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_abs[i] = v_ff[i][32] ? (33'd0 - v_ff[i]) : v_ff[i];
         far_vec[i] = mag_abs[i] > {1'b0, r_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_MAG]) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_abs[i][31:0];
            neg_ff[i] <= v_ff[i][32];
         end
         far_ff  <= |far_vec;
         tpos_ff <= (depth_ff[33] || depth_ff == 34'd0) ? 33'd0 : depth_ff[32:0];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: squares and the table spring term.
   // ------------------------------------------------------------------------
   logic [63:0] sq_ff [3];
   logic [63:0] tprod;
   ctl_type     ctl3_ff;
   ctl_type     ctl4_ff;
   logic        far3_ff;
   logic        far4_ff;

   assign tprod = {31'b0, tpos_ff} * {33'b0, table_spring_gain_ff};

   always_ff @(posedge clock) begin
      if (en[S_SQ]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]       <= {32'b0, mag_ff[i]} * {32'b0, mag_ff[i]};
            ctl3_ff.mag[i] <= mag_ff[i];
         end
         ctl3_ff.neg   <= neg_ff;
         ctl3_ff.hit   <= 1'b0;
         ctl3_ff.tterm <= tprod[63:16];
         far3_ff       <= far_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: exact sum of squares.
   // ------------------------------------------------------------------------
   logic [65:0] sum_ff;

   always_ff @(posedge clock) begin
      if (en[S_SUM]) begin
         sum_ff  <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         ctl4_ff <= ctl3_ff;
         far4_ff <= far3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: contact test. Coincident centers (zero sum) give no contact.
   // An overflowing sum always exceeds the squared radius.
   // ------------------------------------------------------------------------
   logic [63:0] sq_rad_ff  [0:NSQRT];
   logic [33:0] sq_rem_ff  [0:NSQRT];
   logic [31:0] sq_root_ff [0:NSQRT];
   ctl_type     sq_ctl_ff  [0:NSQRT];
   ctl_type     cmp_ctl;

   always_comb begin
      cmp_ctl     = ctl4_ff;
      cmp_ctl.hit = !far4_ff && sum_ff != 66'd0 && sum_ff <= {2'b00, rr_ff};
   end

   always_ff @(posedge clock) begin
      if (en[S_CMP]) begin
         sq_rad_ff[0]  <= sum_ff[63:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_ctl_ff[0]  <= cmp_ctl;
      end
   end

   // ------------------------------------------------------------------------
   // Square root, one result bit per stage, most significant first.
   // ------------------------------------------------------------------------
   for (genvar j = 0; j < NSQRT; j++) begin : g_sqrt
      logic [35:0] remx;
      logic [33:0] trial;
      logic        ge;

      always_comb begin
         remx  = {sq_rem_ff[j], sq_rad_ff[j][63:62]};
         trial = {sq_root_ff[j], 2'b01};
         ge    = remx >= {2'b00, trial};
      end

      always_ff @(posedge clock) begin
         if (en[S_SQRT0+j]) begin
            sq_rad_ff[j+1]  <= {sq_rad_ff[j][61:0], 2'b00};
            sq_rem_ff[j+1]  <= ge ? 34'(remx - {2'b00, trial}) : remx[33:0];
            sq_root_ff[j+1] <= {sq_root_ff[j][30:0], ge};
            sq_ctl_ff[j+1]  <= sq_ctl_ff[j];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Unit vector divisions, one quotient bit per stage for all three axes.
   // The first two stages also form the penetration and the scaled stiffness.
   // ------------------------------------------------------------------------
   div_type dv_ff [1:NDIV];

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      div_type     src;
      div_type     nxt_in;
      logic [32:0] remx [3];
      logic [2:0]  ge;
      logic [63:0] kprod;

      if (j == 0) begin : g_first
         always_comb begin
            src       = '0;
            src.neg   = sq_ctl_ff[NSQRT].neg;
            src.hit   = sq_ctl_ff[NSQRT].hit;
            src.tterm = sq_ctl_ff[NSQRT].tterm;
            src.len   = sq_root_ff[NSQRT];
            for (int i = 0; i < 3; i++) begin
               src.rem[i] = {1'b0, sq_ctl_ff[NSQRT].mag[i][31:1]};
               src.lsb[i] = sq_ctl_ff[NSQRT].mag[i][0];
            end
         end
      end else begin : g_next
         assign src = dv_ff[j];
      end

      assign kprod = {32'b0, src.kx[31:0]} * {33'b0, contact_stiffness_ff};

      always_comb begin
         nxt_in     = src;
         nxt_in.lsb = '0;
         for (int i = 0; i < 3; i++) begin
            remx[i]       = {src.rem[i], src.lsb[i]};
            ge[i]         = remx[i] >= {1'b0, src.len};
            nxt_in.rem[i] = ge[i] ? 32'(remx[i] - {1'b0, src.len}) : remx[i][31:0];
            nxt_in.q[i]   = {src.q[i][29:0], ge[i]};
         end
         if (j == 0) begin
            nxt_in.kx = {15'b0, r_ff - src.len};
         end else if (j == 1) begin
            nxt_in.kx = kprod[62:16];
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_DIV0+j]) begin
            dv_ff[j+1] <= nxt_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Partial products of stiffness and the Q1.30 unit vector, then their sum.
   // ------------------------------------------------------------------------
   logic [53:0] hi_ff [3];
   logic [54:0] lo_ff [3];
   logic [2:0]  pp_neg_ff;
   logic        pp_hit_ff;
   logic [47:0] pp_tterm_ff;

   always_ff @(posedge clock) begin
      if (en[S_PP]) begin
         for (int i = 0; i < 3; i++) begin
            hi_ff[i] <= {31'b0, dv_ff[NDIV].kx[46:24]} * {23'b0, dv_ff[NDIV].q[i]};
            lo_ff[i] <= {31'b0, dv_ff[NDIV].kx[23:0]} * {24'b0, dv_ff[NDIV].q[i]};
         end
         pp_neg_ff   <= dv_ff[NDIV].neg;
         pp_hit_ff   <= dv_ff[NDIV].hit;
         pp_tterm_ff <= dv_ff[NDIV].tterm;
      end
   end

   logic [77:0] mq_sum [3];
   logic [47:0] m_ff [3];
   logic [2:0]  mq_neg_ff;
   logic        mq_hit_ff;
   logic [47:0] mq_tterm_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mq_sum[i] = {hi_ff[i], 24'b0} + {23'b0, lo_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_MQ]) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= pp_hit_ff ? mq_sum[i][77:30] : 48'd0;
         end
         mq_neg_ff   <= pp_neg_ff;
         mq_hit_ff   <= pp_hit_ff;
         mq_tterm_ff <= pp_tterm_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: sign, table spring on z, saturation to 32 bits.
   // ------------------------------------------------------------------------
   logic [49:0] fsum [3];
   logic [31:0] fsat [3];
   logic [31:0] force_x_ff;
   logic [31:0] force_y_ff;
   logic [31:0] force_z_ff;
   logic        in_contact_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fsum[i] = mq_neg_ff[i] ? (50'd0 - {2'b00, m_ff[i]}) : {2'b00, m_ff[i]};
      end
      fsum[2] = fsum[2] + {2'b00, mq_tterm_ff};
      for (int i = 0; i < 3; i++) begin
         if (fsum[i][49:31] == {19{1'b0}} || fsum[i][49:31] == {19{1'b1}}) begin
            fsat[i] = fsum[i][31:0];
         end else if (fsum[i][49]) begin
            fsat[i] = 32'h8000_0000;
         end else begin
            fsat[i] = 32'h7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         force_x_ff    <= fsat[0];
         force_y_ff    <= fsat[1];
         force_z_ff    <= fsat[2];
         in_contact_ff <= mq_hit_ff;
      end
   end

   assign rsp_ch.valid      = vld_ff[S_OUT];
   assign rsp_ch.force_x    = force_x_ff;
   assign rsp_ch.force_y    = force_y_ff;
   assign rsp_ch.force_z    = force_z_ff;
   assign rsp_ch.in_contact = in_contact_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[S_DIFF])
      else $error("accepted beat did not enter the first stage");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_DIV0-1] && sq_ctl_ff[NSQRT].hit |-> sq_root_ff[NSQRT] <= r_ff)
      else $error("root of a contact exceeds the summed radius");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_PP-1] && dv_ff[NDIV].hit |->
         dv_ff[NDIV].q[0] <= scpf_pkg::UNIT_ONE && dv_ff[NDIV].q[1] <= scpf_pkg::UNIT_ONE
         && dv_ff[NDIV].q[2] <= scpf_pkg::UNIT_ONE)
      else $error("unit vector component above one");

   a_no_contact_xy: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.in_contact |-> rsp_ch.force_x == 0 && rsp_ch.force_y == 0)
      else $error("lateral force without contact");

endmodule
`default_nettype wire
